@@ rtl/core/pnm_image_stream_decoder_defines.svh @@
// Assertion macros for the PNM stream decoder.
// Included by the modules that check their own logic; needs clk and rst in scope.
`ifndef PNM_IMAGE_STREAM_DECODER_DEFINES_SVH
`define PNM_IMAGE_STREAM_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// condition holds at every edge out of reset
`define PNM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// antecedent implies consequent in the next cycle
`define PNM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PNM_ASSERT(lbl, cond, msg)
`define PNM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/pnm_pkg.sv @@
// Shared types, codes and helpers for the PNM stream decoder.
// No dependencies.
`timescale 1ns / 1ps
package pnm_pkg;

  localparam int DIM_BITS_DEF = 16;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_MAGIC    = 3'd0;
  localparam logic [2:0] ERR_DIGIT    = 3'd1;
  localparam logic [2:0] ERR_CHAR     = 3'd2;
  localparam logic [2:0] ERR_END_NUM  = 3'd3;
  localparam logic [2:0] ERR_END_CMT  = 3'd4;
  localparam logic [2:0] ERR_SHORT    = 3'd5;
  localparam logic [2:0] ERR_ZERO_MAX = 3'd6;

  // format digits
  localparam logic [2:0] FMT_NONE = 3'd0;
  localparam logic [2:0] FMT_P1   = 3'd1;
  localparam logic [2:0] FMT_P3   = 3'd3;
  localparam logic [2:0] FMT_P4   = 3'd4;
  localparam logic [2:0] FMT_P6   = 3'd6;

  // characters
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;

  localparam logic [15:0] NUM_SAT    = 16'hFFFF;
  localparam logic [7:0]  SAMPLE_MAX = 8'd255;
  localparam logic [2:0]  BIT_MSB    = 3'd7;

  // datapath commands, one per cycle
  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_LOAD     = 4'd1,
    CMD_ACCUM    = 4'd2,
    CMD_FINISH   = 4'd3,
    CMD_MUL      = 4'd4,
    CMD_COUNT    = 4'd5,
    CMD_DIV_STEP = 4'd6,
    CMD_DIV_OUT  = 4'd7,
    CMD_EMIT     = 4'd8,
    CMD_BYTE     = 4'd9,
    CMD_TAIL     = 4'd10,
    CMD_REARM    = 4'd11
  } pnm_cmd_t;

  // datapath status towards the controller
  typedef struct packed {
    logic num_active;   // inside a number in a header or sample phase
    logic digit;        // held byte is a decimal digit
    logic eof;          // held item is the end mark
    logic fin_count;    // finishing the number starts the data count
    logic fin_div;      // finishing the number needs a scale division
    logic fin_emit;     // finishing the number makes a result
    logic div_done;     // divider has its quotient
    logic hdl_emit;     // byte or end handling makes a result
    logic out_free;     // output register can take a word
  } pnm_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

@@ rtl/core/pnm_byte_if.sv @@
// Input channel of the PNM decoder: one file byte or end mark per word.
// No dependencies.
`timescale 1ns / 1ps
interface pnm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       end_of_file;

  modport source (output valid, byte_req, end_of_file, input ready);
  modport sink   (input valid, byte_req, end_of_file, output ready);
endinterface

@@ rtl/core/pnm_res_if.sv @@
// Result channel of the PNM decoder: header, data byte or error per word.
// No dependencies.
`timescale 1ns / 1ps
interface pnm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  format_code;
  logic [15:0] width;
  logic [15:0] height;
  logic [15:0] max_value;
  logic [7:0]  data_byte;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, kind, format_code, width, height, max_value, data_byte,
                  error_code, last, input ready);
  modport sink   (input valid, kind, format_code, width, height, max_value, data_byte,
                  error_code, last, output ready);
endinterface

@@ rtl/core/pnm_dp.sv @@
// Datapath of the PNM decoder: parse state, header fields, counters, divider,
// output register. Depends on pnm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pnm_image_stream_decoder_defines.svh"
module pnm_dp #(
  parameter int DIM_BITS = pnm_pkg::DIM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pnm_pkg::pnm_cmd_t   cmd,
  output pnm_pkg::pnm_status_t sts,
  input  logic [7:0]          byte_req,
  input  logic                end_of_file,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          kind,
  output logic [2:0]          format_code,
  output logic [15:0]         width,
  output logic [15:0]         height,
  output logic [15:0]         max_value,
  output logic [7:0]          data_byte,
  output logic [2:0]          error_code,
  output logic                last
);
  import pnm_pkg::*;

  localparam int CNT_W = 2 * DIM_BITS + 2;
  localparam logic [15:0] DIM_LIM = 16'((32'd1 << DIM_BITS) - 32'd1);

  typedef enum logic [8:0] {
    PH_MAGIC = 9'b000000001,
    PH_DIGIT = 9'b000000010,
    PH_HDR_W = 9'b000000100,
    PH_HDR_H = 9'b000001000,
    PH_HDR_M = 9'b000010000,
    PH_ASCII = 9'b000100000,
    PH_SEP   = 9'b001000000,
    PH_RAW   = 9'b010000000,
    PH_DONE  = 9'b100000000
  } phase_t;

  phase_t                phase;
  logic [7:0]            c_q;
  logic                  eof_q;
  logic [2:0]            fmt;
  logic [DIM_BITS-1:0]   width_h;
  logic [DIM_BITS-1:0]   height_h;
  logic [15:0]           max_h;
  logic [15:0]           acc;
  logic                  in_number;
  logic                  in_comment;
  logic [CNT_W-1:0]      remaining;
  logic [DIM_BITS-1:0]   col;
  logic [2:0]            bitpos;
  logic [7:0]            packed_bits;
  logic [2*DIM_BITS-1:0] prod;
  logic [15:0]           div_rem;
  logic [15:0]           div_num;
  logic [3:0]            div_cnt;
  logic                  div_done;
  logic [1:0]            res_kind;
  logic [7:0]            res_data;
  logic [2:0]            res_err;
  logic                  res_last;

  logic                  num_phase;
  logic                  fmt_bitmap;
  logic [19:0]           acc_mul;
  logic [15:0]           acc_next;
  logic [DIM_BITS-1:0]   dim_clamped;
  logic [7:0]            sample;
  logic [15:0]           scaled;
  logic [7:0]            pk_next;
  logic [DIM_BITS-1:0]   col_next;
  logic                  pk_flush;
  logic [DIM_BITS-1:0]   w_sel;
  logic [DIM_BITS:0]     w_round;
  logic [CNT_W-1:0]      cnt;
  logic [16:0]           div_shift;
  logic [16:0]           div_trial;
  logic [15:0]           divisor;
  logic                  last_data;

  // decode of the held state
  always_comb begin
    num_phase   = (phase inside {PH_HDR_W, PH_HDR_H, PH_HDR_M, PH_ASCII});
    fmt_bitmap  = (fmt inside {FMT_P1, FMT_P4});
    acc_mul     = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {16'd0, c_q[3:0]};
    acc_next    = (acc_mul > {4'd0, NUM_SAT}) ? NUM_SAT : acc_mul[15:0];
    dim_clamped = (acc > DIM_LIM) ? DIM_LIM[DIM_BITS-1:0] : acc[DIM_BITS-1:0];
    sample      = (acc > {8'd0, SAMPLE_MAX}) ? SAMPLE_MAX : acc[7:0];
    scaled      = {sample, 8'd0} - {8'd0, sample};
    pk_next     = packed_bits | ((acc != 16'd0) ? (8'd1 << bitpos) : 8'd0);
    col_next    = col + 1'b1;
    pk_flush    = (bitpos == 3'd0) || (col_next >= width_h);
    w_round     = ({1'b0, width_h} + (DIM_BITS+1)'(7)) >> 3;
    w_sel       = fmt_bitmap ? w_round[DIM_BITS-1:0] : width_h;
    cnt         = (fmt inside {FMT_P3, FMT_P6}) ?
                  ({2'b00, prod} + {1'b0, prod, 1'b0}) : {2'b00, prod};
    divisor     = (max_h == 16'd0) ? 16'd1 : max_h;
    div_shift   = {div_rem, div_num[15]};
    div_trial   = div_shift - {1'b0, divisor};
    last_data   = (remaining == CNT_W'(1));
  end

  // status towards the controller
  always_comb begin
    sts.num_active = num_phase && in_number;
    sts.digit      = is_digit(c_q);
    sts.eof        = eof_q;
    sts.fin_count  = ((phase == PH_HDR_H) && fmt_bitmap) ||
                     ((phase == PH_HDR_M) && (acc != 16'd0));
    sts.fin_div    = (phase == PH_ASCII) && (fmt != FMT_P1);
    sts.fin_emit   = ((phase == PH_HDR_M) && (acc == 16'd0)) ||
                     ((phase == PH_ASCII) && (fmt == FMT_P1) && pk_flush);
    sts.div_done   = div_done;
    sts.out_free   = !out_valid || out_ready;
    if (eof_q) begin
      sts.hdl_emit = (phase != PH_DONE);
    end else begin
      case (phase)
        PH_MAGIC: sts.hdl_emit = (c_q != CH_P);
        PH_DIGIT: sts.hdl_emit = !((c_q >= CH_ONE) && (c_q <= CH_SIX));
        PH_HDR_W, PH_HDR_H, PH_HDR_M, PH_ASCII:
          sts.hdl_emit = !in_comment && !is_digit(c_q) && (c_q != CH_HASH) &&
                         !is_space(c_q);
        PH_RAW:   sts.hdl_emit = 1'b1;
        default:  sts.hdl_emit = 1'b0;
      endcase
    end
  end

  // parse state and held fields
  always_ff @(posedge clk) begin
    if (rst || (cmd == CMD_REARM)) begin
      phase       <= PH_MAGIC;
      fmt         <= FMT_NONE;
      width_h     <= '0;
      height_h    <= '0;
      max_h       <= 16'd1;
      acc         <= 16'd0;
      in_number   <= 1'b0;
      in_comment  <= 1'b0;
      remaining   <= '0;
      col         <= '0;
      bitpos      <= BIT_MSB;
      packed_bits <= 8'd0;
      div_done    <= 1'b0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          c_q   <= byte_req;
          eof_q <= end_of_file;
        end
        CMD_ACCUM: acc <= acc_next;
        CMD_FINISH: begin
          in_number <= 1'b0;
          case (phase)
            PH_HDR_W: begin
              width_h <= dim_clamped;
              phase   <= PH_HDR_H;
            end
            PH_HDR_H: begin
              height_h <= dim_clamped;
              if (fmt_bitmap) max_h <= 16'd1;
              else            phase <= PH_HDR_M;
            end
            PH_HDR_M: begin
              if (acc == 16'd0) begin
                res_kind <= KIND_ERROR;
                res_data <= 8'd0;
                res_err  <= ERR_ZERO_MAX;
                res_last <= 1'b1;
                phase    <= PH_DONE;
              end else begin
                max_h <= acc;
              end
            end
            PH_ASCII: begin
              if (fmt == FMT_P1) begin
                // pack one bit, flush at a full byte or row end
                if (pk_flush) begin
                  packed_bits <= 8'd0;
                  bitpos      <= BIT_MSB;
                  col         <= (col_next >= width_h) ? '0 : col_next;
                  res_kind    <= KIND_DATA;
                  res_data    <= pk_next;
                  res_err     <= ERR_MAGIC;
                  res_last    <= last_data;
                  remaining   <= remaining - 1'b1;
                  if (last_data) phase <= PH_DONE;
                end else begin
                  packed_bits <= pk_next;
                  bitpos      <= bitpos - 1'b1;
                  col         <= col_next;
                end
              end else begin
                div_rem  <= 16'd0;
                div_num  <= scaled;
                div_cnt  <= 4'd0;
                div_done <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        CMD_MUL: prod <= height_h * w_sel;
        CMD_COUNT: begin
          // data count known: header out, enter data phase (or done if there is no data)
          remaining   <= cnt;
          res_kind    <= KIND_HEADER;
          res_data    <= 8'd0;
          res_err     <= ERR_MAGIC;
          res_last    <= (prod == '0);
          col         <= '0;
          bitpos      <= BIT_MSB;
          packed_bits <= 8'd0;
          if (prod == '0)          phase <= PH_DONE;
          else if (fmt <= FMT_P3)  phase <= PH_ASCII;
          else                     phase <= PH_SEP;
        end
        CMD_DIV_STEP: begin
          // one restoring divide step per cycle
          if (!div_trial[16]) begin
            div_rem <= div_trial[15:0];
            div_num <= {div_num[14:0], 1'b1};
          end else begin
            div_rem <= div_shift[15:0];
            div_num <= {div_num[14:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 4'hF) div_done <= 1'b1;
        end
        CMD_DIV_OUT: begin
          div_done  <= 1'b0;
          res_kind  <= KIND_DATA;
          res_data  <= div_num[7:0];
          res_err   <= ERR_MAGIC;
          res_last  <= last_data;
          remaining <= remaining - 1'b1;
          if (last_data) phase <= PH_DONE;
        end
        CMD_BYTE: begin
          res_kind <= KIND_ERROR;
          res_data <= 8'd0;
          res_last <= 1'b1;
          case (phase)
            PH_MAGIC: begin
              res_err <= ERR_MAGIC;
              phase   <= (c_q == CH_P) ? PH_DIGIT : PH_DONE;
            end
            PH_DIGIT: begin
              res_err <= ERR_DIGIT;
              if ((c_q >= CH_ONE) && (c_q <= CH_SIX)) begin
                fmt   <= c_q[2:0];
                phase <= PH_HDR_W;
              end else begin
                phase <= PH_DONE;
              end
            end
            PH_HDR_W, PH_HDR_H, PH_HDR_M, PH_ASCII: begin
              res_err <= ERR_CHAR;
              if (in_comment) begin
                if (c_q == CH_LF) in_comment <= 1'b0;
              end else if (is_digit(c_q)) begin
                in_number <= 1'b1;
                acc       <= {12'd0, c_q[3:0]};
              end else if (c_q == CH_HASH) begin
                in_comment <= 1'b1;
              end else if (!is_space(c_q)) begin
                phase <= PH_DONE;
              end
            end
            PH_SEP: phase <= PH_RAW;
            PH_RAW: begin
              res_kind  <= KIND_DATA;
              res_data  <= c_q;
              res_err   <= ERR_MAGIC;
              res_last  <= last_data;
              remaining <= remaining - 1'b1;
              if (last_data) phase <= PH_DONE;
            end
            default: ;
          endcase
        end
        CMD_TAIL: begin
          // end mark: error from where the file stopped
          res_kind <= KIND_ERROR;
          res_data <= 8'd0;
          res_last <= 1'b1;
          case (phase)
            PH_MAGIC: res_err <= ERR_MAGIC;
            PH_DIGIT: res_err <= ERR_DIGIT;
            PH_SEP, PH_RAW: res_err <= ERR_SHORT;
            default:  res_err <= in_comment ? ERR_END_CMT : ERR_END_NUM;
          endcase
          phase <= PH_DONE;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_EMIT) begin
      kind        <= res_kind;
      format_code <= fmt;
      width       <= 16'(width_h);
      height      <= 16'(height_h);
      max_value   <= max_h;
      data_byte   <= res_data;
      error_code  <= (res_kind == KIND_ERROR) ? res_err : ERR_MAGIC;
      last        <= res_last;
    end
  end

  `PNM_ASSERT(a_count_live, !((phase == PH_ASCII) || (phase == PH_SEP) || (phase == PH_RAW)) || (remaining != '0), "data phase with zero count")
  `PNM_ASSERT(a_err_last, !(out_valid && (kind == KIND_ERROR)) || last, "error word without last")
  `PNM_ASSERT(a_col_range, !((phase == PH_ASCII) && (fmt == FMT_P1)) || (col < width_h), "bitmap column past width")

endmodule

@@ rtl/core/pnm_ctrl.sv @@
// Controller of the PNM decoder: sequences the datapath steps of one item.
// Depends on pnm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pnm_image_stream_decoder_defines.svh"
module pnm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pnm_pkg::pnm_status_t sts,
  output pnm_pkg::pnm_cmd_t    cmd
);
  import pnm_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECODE = 11'b00000000010,
    S_FINISH = 11'b00000000100,
    S_MUL    = 11'b00000001000,
    S_COUNT  = 11'b00000010000,
    S_DIV    = 11'b00000100000,
    S_DIVOUT = 11'b00001000000,
    S_EMIT_A = 11'b00010000000,
    S_HANDLE = 11'b00100000000,
    S_EMIT_B = 11'b01000000000,
    S_REARM  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // next state and command
  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.num_active && !sts.eof && sts.digit) begin
          cmd        = CMD_ACCUM;
          state_next = S_IDLE;
        end else if (sts.num_active) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_HANDLE;
        end
      end
      S_FINISH: begin
        cmd = CMD_FINISH;
        if (sts.fin_count)     state_next = S_MUL;
        else if (sts.fin_div)  state_next = S_DIV;
        else if (sts.fin_emit) state_next = S_EMIT_A;
        else                   state_next = S_HANDLE;
      end
      S_MUL: begin
        cmd        = CMD_MUL;
        state_next = S_COUNT;
      end
      S_COUNT: begin
        cmd        = CMD_COUNT;
        state_next = S_EMIT_A;
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_DIVOUT;
        else              cmd = CMD_DIV_STEP;
      end
      S_DIVOUT: begin
        cmd        = CMD_DIV_OUT;
        state_next = S_EMIT_A;
      end
      S_EMIT_A: begin
        if (sts.out_free) begin
          cmd        = CMD_EMIT;
          state_next = S_HANDLE;
        end
      end
      S_HANDLE: begin
        cmd = sts.eof ? CMD_TAIL : CMD_BYTE;
        if (sts.hdl_emit)  state_next = S_EMIT_B;
        else if (sts.eof)  state_next = S_REARM;
        else               state_next = S_IDLE;
      end
      S_EMIT_B: begin
        if (sts.out_free) begin
          cmd        = CMD_EMIT;
          state_next = sts.eof ? S_REARM : S_IDLE;
        end
      end
      S_REARM: begin
        cmd        = CMD_REARM;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  `PNM_ASSERT(a_emit_free, (cmd != CMD_EMIT) || sts.out_free, "word emitted into a full output register")
  `PNM_ASSERT_NEXT(a_accept_decode, (state == S_IDLE) && in_valid, state == S_DECODE, "accepted word not decoded")
  `PNM_ASSERT_NEXT(a_div_out, (state == S_DIV) && sts.div_done, state == S_DIVOUT, "quotient not taken")

endmodule

@@ rtl/core/pnm_image_stream_decoder.sv @@
// PNM (P1..P6) stream decoder, top level.
// Depends on pnm_pkg, pnm_byte_if, pnm_res_if, pnm_ctrl and pnm_dp.
//
// Usage: byte_ch carries one file byte per word, or an end mark
// (end_of_file set, byte ignored). res_ch returns a header word, then the
// pixel bytes; an error word ends the image. last flags the final word of
// an image, every error and a header with no data. An end mark closes the
// image and rearms the decoder for the next file.
// Timing: one item at a time. A header or separator byte is loaded, decoded
// and handled; a digit inside a number is loaded and accumulated; a byte
// that ends a number adds a finish step. A P2 or P3 sample ends its number
// and runs a restoring divider at one quotient bit per cycle; the header
// result adds a multiplier stage and a count stage.
// Results leave through a single output register; while the receiver
// stalls the decoder holds at its next result and takes no new word.
// Reset (rst, synchronous) returns the decoder to waiting for the magic.
`timescale 1ns / 1ps
module pnm_image_stream_decoder #(
  parameter int DIM_BITS = pnm_pkg::DIM_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  pnm_byte_if.sink  byte_ch,
  pnm_res_if.source res_ch
);
  import pnm_pkg::*;

  pnm_cmd_t    cmd;
  pnm_status_t sts;

  pnm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_ch.valid),
    .in_ready (byte_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pnm_dp #(.DIM_BITS(DIM_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .byte_req    (byte_ch.byte_req),
    .end_of_file (byte_ch.end_of_file),
    .out_ready   (res_ch.ready),
    .out_valid   (res_ch.valid),
    .kind        (res_ch.kind),
    .format_code (res_ch.format_code),
    .width       (res_ch.width),
    .height      (res_ch.height),
    .max_value   (res_ch.max_value),
    .data_byte   (res_ch.data_byte),
    .error_code  (res_ch.error_code),
    .last        (res_ch.last)
  );

endmodule
